@@ rtl/core/cpdd_pkg.sv @@
package cpdd_pkg;

    // Fixed-point format of every position, velocity, command and result.
    localparam int FRAC_BITS  = 16;
    localparam int WORD_W     = 32;
    localparam int GAIN_W     = 31;

    // Magnitude of a position difference always fits in one word.
    localparam int MAG_W      = WORD_W;
    localparam int SQ_W       = 2 * MAG_W + 1;
    localparam int ROOT_W     = (SQ_W + 1) / 2;
    localparam int SQRT_PAD_W = 2 * ROOT_W;
    localparam int SQRT_REM_W = ROOT_W + 4;
    localparam int DEN_W      = SQ_W + ROOT_W;
    localparam int PROD_W     = GAIN_W + MAG_W;
    localparam int NUM_W      = PROD_W + 2 * FRAC_BITS;

    // The coupling magnitude is held at 2^(CAP_W-1).
    localparam int CAP_W      = 34;
    localparam int Q_BITS     = CAP_W + 1;
    localparam logic [CAP_W-1:0] COUPLE_CAP = CAP_W'(1) << (CAP_W - 1);

    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(1) << FRAC_BITS;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // One classified item as it travels from the front to the back.
    typedef struct packed {
        logic signed [WORD_W-1:0] vel1_x;
        logic signed [WORD_W-1:0] vel1_y;
        logic signed [WORD_W-1:0] vel2_x;
        logic signed [WORD_W-1:0] vel2_y;
        logic signed [WORD_W-1:0] cmd1_x;
        logic signed [WORD_W-1:0] cmd1_y;
        logic signed [WORD_W-1:0] cmd2_x;
        logic signed [WORD_W-1:0] cmd2_y;
        logic [MAG_W-1:0]         mag_x;
        logic [MAG_W-1:0]         mag_y;
        logic                     neg_x;
        logic                     neg_y;
        logic                     coincident;
    } item_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

endpackage

@@ rtl/core/coupled_pair_dynamics_derivative_core.sv @@
// Channel   Signals                                   Moves
// input     in_valid / in_stall, pos*, vel*, cmd*     one state sample per transfer
// output    out_valid / out_stall, dpos*, dvel*, flags one derivative per transfer
// config    cfg_we, cfg_wdata                         coupling gain
//
// One sample can be accepted every cycle while in_stall is low; the back pipeline
// holds the 33-stage square root and the two 36-stage dividers.
// Reset is asynchronous and active low; it empties all stages and sets the gain to 1.0.
// A stalled output that holds a result freezes the back; the four-entry queue and
// the front register keep accepting until they fill, then in_stall rises.
module coupled_pair_dynamics_derivative_core import cpdd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [GAIN_W-1:0]        cfg_wdata,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [WORD_W-1:0] pos1_x,
    input  logic signed [WORD_W-1:0] pos1_y,
    input  logic signed [WORD_W-1:0] vel1_x,
    input  logic signed [WORD_W-1:0] vel1_y,
    input  logic signed [WORD_W-1:0] pos2_x,
    input  logic signed [WORD_W-1:0] pos2_y,
    input  logic signed [WORD_W-1:0] vel2_x,
    input  logic signed [WORD_W-1:0] vel2_y,
    input  logic signed [WORD_W-1:0] cmd1_x,
    input  logic signed [WORD_W-1:0] cmd1_y,
    input  logic signed [WORD_W-1:0] cmd2_x,
    input  logic signed [WORD_W-1:0] cmd2_y,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [WORD_W-1:0] dpos1_x,
    output logic signed [WORD_W-1:0] dpos1_y,
    output logic signed [WORD_W-1:0] dvel1_x,
    output logic signed [WORD_W-1:0] dvel1_y,
    output logic signed [WORD_W-1:0] dpos2_x,
    output logic signed [WORD_W-1:0] dpos2_y,
    output logic signed [WORD_W-1:0] dvel2_x,
    output logic signed [WORD_W-1:0] dvel2_y,
    output logic                     coincident,
    output logic                     saturated
);

    logic [GAIN_W-1:0] gain_reg;
    queue_status_t     qstat;
    logic              push;
    logic              pop;
    item_t             push_item;
    item_t             pop_item;

    // Coupling gain register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
        end
        else if (cfg_we)
        begin
            gain_reg <= cfg_wdata;
        end
    end

    cpdd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pos1_x    (pos1_x),
        .pos1_y    (pos1_y),
        .vel1_x    (vel1_x),
        .vel1_y    (vel1_y),
        .pos2_x    (pos2_x),
        .pos2_y    (pos2_y),
        .vel2_x    (vel2_x),
        .vel2_y    (vel2_y),
        .cmd1_x    (cmd1_x),
        .cmd1_y    (cmd1_y),
        .cmd2_x    (cmd2_x),
        .cmd2_y    (cmd2_y),
        .qstat     (qstat),
        .push      (push),
        .push_item (push_item)
    );

    cpdd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .status    (qstat)
    );

    cpdd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .gain       (gain_reg),
        .qstat      (qstat),
        .pop_item   (pop_item),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .dpos1_x    (dpos1_x),
        .dpos1_y    (dpos1_y),
        .dvel1_x    (dvel1_x),
        .dvel1_y    (dvel1_y),
        .dpos2_x    (dpos2_x),
        .dpos2_y    (dpos2_y),
        .dvel2_x    (dvel2_x),
        .dvel2_y    (dvel2_y),
        .coincident (coincident),
        .saturated  (saturated)
    );

endmodule

@@ rtl/core/cpdd_front.sv @@
module cpdd_front import cpdd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [WORD_W-1:0] pos1_x,
    input  logic signed [WORD_W-1:0] pos1_y,
    input  logic signed [WORD_W-1:0] vel1_x,
    input  logic signed [WORD_W-1:0] vel1_y,
    input  logic signed [WORD_W-1:0] pos2_x,
    input  logic signed [WORD_W-1:0] pos2_y,
    input  logic signed [WORD_W-1:0] vel2_x,
    input  logic signed [WORD_W-1:0] vel2_y,
    input  logic signed [WORD_W-1:0] cmd1_x,
    input  logic signed [WORD_W-1:0] cmd1_y,
    input  logic signed [WORD_W-1:0] cmd2_x,
    input  logic signed [WORD_W-1:0] cmd2_y,
    input  queue_status_t            qstat,
    output logic                     push,
    output item_t                    push_item
);

    logic signed [WORD_W:0] dx;
    logic signed [WORD_W:0] dy;
    logic [WORD_W:0]        abs_x;
    logic [WORD_W:0]        abs_y;
    item_t                  item_next;
    item_t                  item_reg;
    logic                   valid_reg;

    // Exact differences and their magnitudes.
    assign dx    = {pos2_x[WORD_W-1], pos2_x} - {pos1_x[WORD_W-1], pos1_x};
    assign dy    = {pos2_y[WORD_W-1], pos2_y} - {pos1_y[WORD_W-1], pos1_y};
    assign abs_x = dx[WORD_W] ? -dx : dx;
    assign abs_y = dy[WORD_W] ? -dy : dy;

    always_comb
    begin
        item_next.vel1_x     = vel1_x;
        item_next.vel1_y     = vel1_y;
        item_next.vel2_x     = vel2_x;
        item_next.vel2_y     = vel2_y;
        item_next.cmd1_x     = cmd1_x;
        item_next.cmd1_y     = cmd1_y;
        item_next.cmd2_x     = cmd2_x;
        item_next.cmd2_y     = cmd2_y;
        item_next.mag_x      = abs_x[MAG_W-1:0];
        item_next.mag_y      = abs_y[MAG_W-1:0];
        item_next.neg_x      = dx[WORD_W];
        item_next.neg_y      = dy[WORD_W];
        item_next.coincident = (dx == '0) && (dy == '0);
    end

    // The front register holds a valid item while the queue is full.
    assign in_stall  = valid_reg && qstat.full;
    assign push      = valid_reg && !qstat.full;
    assign push_item = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

@@ rtl/core/cpdd_queue.sv @@
module cpdd_queue import cpdd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  item_t         push_item,
    input  logic          pop,
    output item_t         pop_item,
    output queue_status_t status
);

    item_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign pop_item     = entry_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (QPTR_W+1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (QPTR_W+1)'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QPTR_W+1)'(QUEUE_DEPTH))
        else $error("queue fill count out of range");

    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg != '0)
        else $error("queue empty after a lone write");

endmodule

@@ rtl/core/cpdd_divider.sv @@
module cpdd_divider import cpdd_pkg::*;
(
    input  logic             clk,
    input  logic             adv,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [CAP_W-1:0] quot
);

    localparam int DIV_W = DEN_W + Q_BITS;

    logic [NUM_W-1:0]  rem_reg [0:Q_BITS];
    logic [DEN_W-1:0]  den_reg [0:Q_BITS];
    logic [Q_BITS-1:0] q_reg   [0:Q_BITS];
    logic              ovf_reg [0:Q_BITS];

    // Entry stage: detect a quotient too large for the bit stages.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= DEN_W'(num >> Q_BITS) >= den;
        end
    end

    // One restoring quotient bit per stage, most significant first.
    for (genvar i = 1; i <= Q_BITS; i++)
    begin : g_bit
        localparam int B = Q_BITS - i;
        logic [DIV_W-1:0] trial;
        logic             fits;

        assign trial = DIV_W'(den_reg[i-1]) << B;
        assign fits  = DIV_W'(rem_reg[i-1]) >= trial;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[i] <= fits ? NUM_W'(DIV_W'(rem_reg[i-1]) - trial) : rem_reg[i-1];
                q_reg[i]   <= q_reg[i-1] | (fits ? (Q_BITS'(1) << B) : '0);
                den_reg[i] <= den_reg[i-1];
                ovf_reg[i] <= ovf_reg[i-1];
            end
        end
    end

    // Hold large quotients at the cap.
    assign quot = (ovf_reg[Q_BITS] || (q_reg[Q_BITS] > Q_BITS'(COUPLE_CAP)))
                  ? COUPLE_CAP : q_reg[Q_BITS][CAP_W-1:0];

endmodule

@@ rtl/core/cpdd_back.sv @@
module cpdd_back import cpdd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [GAIN_W-1:0]        gain,
    input  queue_status_t            qstat,
    input  item_t                    pop_item,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [WORD_W-1:0] dpos1_x,
    output logic signed [WORD_W-1:0] dpos1_y,
    output logic signed [WORD_W-1:0] dvel1_x,
    output logic signed [WORD_W-1:0] dvel1_y,
    output logic signed [WORD_W-1:0] dpos2_x,
    output logic signed [WORD_W-1:0] dpos2_y,
    output logic signed [WORD_W-1:0] dvel2_x,
    output logic signed [WORD_W-1:0] dvel2_y,
    output logic                     coincident,
    output logic                     saturated
);

    localparam int DIV_LAT = Q_BITS + 1;
    localparam int SUM_W   = CAP_W + 2;

    logic adv;

    // Stage a: squares and gain products.
    logic                  valid_a_reg;
    item_t                 item_a_reg;
    logic [2*MAG_W-1:0]    sqx_a_reg;
    logic [2*MAG_W-1:0]    sqy_a_reg;
    logic [PROD_W-1:0]     gx_a_reg;
    logic [PROD_W-1:0]     gy_a_reg;

    // Square-root stages; entry 0 holds the sum of squares.
    logic                  rt_valid_reg [0:ROOT_W];
    item_t                 rt_item_reg  [0:ROOT_W];
    logic [SQ_W-1:0]       rt_s_reg     [0:ROOT_W];
    logic [SQRT_REM_W-1:0] rt_rem_reg   [0:ROOT_W];
    logic [ROOT_W-1:0]     rt_root_reg  [0:ROOT_W];
    logic [PROD_W-1:0]     rt_gx_reg    [0:ROOT_W];
    logic [PROD_W-1:0]     rt_gy_reg    [0:ROOT_W];

    // Stage c: partial products of the denominator.
    logic                  valid_c_reg;
    item_t                 item_c_reg;
    logic [MAG_W+ROOT_W-1:0]        plo_c_reg;
    logic [SQ_W-MAG_W+ROOT_W-1:0]   phi_c_reg;
    logic [PROD_W-1:0]     gx_c_reg;
    logic [PROD_W-1:0]     gy_c_reg;

    // Stage d: divider operands.
    logic                  valid_d_reg;
    item_t                 item_d_reg;
    logic [DEN_W-1:0]      den_d_reg;
    logic [NUM_W-1:0]      numx_d_reg;
    logic [NUM_W-1:0]      numy_d_reg;

    // Side data alongside the dividers.
    logic                  dl_valid_reg [0:DIV_LAT-1];
    item_t                 dl_item_reg  [0:DIV_LAT-1];

    logic [CAP_W-1:0]      quot_x;
    logic [CAP_W-1:0]      quot_y;

    // Output register.
    logic                     out_valid_reg;
    logic signed [WORD_W-1:0] dvel1_x_reg;
    logic signed [WORD_W-1:0] dvel1_y_reg;
    logic signed [WORD_W-1:0] dvel2_x_reg;
    logic signed [WORD_W-1:0] dvel2_y_reg;
    logic signed [WORD_W-1:0] dpos1_x_reg;
    logic signed [WORD_W-1:0] dpos1_y_reg;
    logic signed [WORD_W-1:0] dpos2_x_reg;
    logic signed [WORD_W-1:0] dpos2_y_reg;
    logic                     coincident_reg;
    logic                     saturated_reg;

    item_t                    fin;
    logic signed [SUM_W-1:0]  ax;
    logic signed [SUM_W-1:0]  ay;
    logic signed [SUM_W-1:0]  sum1x;
    logic signed [SUM_W-1:0]  sum1y;
    logic signed [SUM_W-1:0]  sum2x;
    logic signed [SUM_W-1:0]  sum2y;

    function automatic logic clips(input logic signed [SUM_W-1:0] v);
        return !((v[SUM_W-1:WORD_W-1] == '0) || (v[SUM_W-1:WORD_W-1] == '1));
    endfunction

    function automatic logic [WORD_W-1:0] clip_word(input logic signed [SUM_W-1:0] v);
        logic [WORD_W-1:0] r;
        if (!clips(v))
        begin
            r = v[WORD_W-1:0];
        end
        else if (v[SUM_W-1])
        begin
            r = {1'b1, {(WORD_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(WORD_W-1){1'b1}}};
        end
        return r;
    endfunction

    // The whole back moves together unless a finished result is held.
    assign adv = !out_valid_reg || !out_stall;
    assign pop = adv && !qstat.empty;

    // Valid bits of every stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_c_reg <= 1'b0;
            valid_d_reg <= 1'b0;
            for (int k = 0; k <= ROOT_W; k++)
            begin
                rt_valid_reg[k] <= 1'b0;
            end
            for (int j = 0; j < DIV_LAT; j++)
            begin
                dl_valid_reg[j] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_a_reg     <= pop;
            rt_valid_reg[0] <= valid_a_reg;
            for (int k = 1; k <= ROOT_W; k++)
            begin
                rt_valid_reg[k] <= rt_valid_reg[k-1];
            end
            valid_c_reg     <= rt_valid_reg[ROOT_W];
            valid_d_reg     <= valid_c_reg;
            dl_valid_reg[0] <= valid_d_reg;
            for (int j = 1; j < DIV_LAT; j++)
            begin
                dl_valid_reg[j] <= dl_valid_reg[j-1];
            end
            out_valid_reg <= dl_valid_reg[DIV_LAT-1];
        end
    end

    // Squares and gain products, then the sum of the squares.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_a_reg <= pop_item;
            sqx_a_reg  <= (2*MAG_W)'(pop_item.mag_x) * (2*MAG_W)'(pop_item.mag_x);
            sqy_a_reg  <= (2*MAG_W)'(pop_item.mag_y) * (2*MAG_W)'(pop_item.mag_y);
            gx_a_reg   <= PROD_W'(gain) * PROD_W'(pop_item.mag_x);
            gy_a_reg   <= PROD_W'(gain) * PROD_W'(pop_item.mag_y);

            rt_item_reg[0] <= item_a_reg;
            rt_s_reg[0]    <= SQ_W'(sqx_a_reg) + SQ_W'(sqy_a_reg);
            rt_rem_reg[0]  <= '0;
            rt_root_reg[0] <= '0;
            rt_gx_reg[0]   <= gx_a_reg;
            rt_gy_reg[0]   <= gy_a_reg;
        end
    end

    // Integer square root, one result bit per stage.
    for (genvar k = 1; k <= ROOT_W; k++)
    begin : g_root
        localparam int LO = 2 * (ROOT_W - k);
        logic [SQRT_PAD_W-1:0] s_pad;
        logic [SQRT_REM_W-1:0] remsh;
        logic [SQRT_REM_W-1:0] trial;
        logic                  fits;

        assign s_pad = SQRT_PAD_W'(rt_s_reg[k-1]);
        assign remsh = {rt_rem_reg[k-1][SQRT_REM_W-3:0], s_pad[LO+1:LO]};
        assign trial = SQRT_REM_W'({rt_root_reg[k-1], 2'b01});
        assign fits  = remsh >= trial;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rt_rem_reg[k]  <= fits ? (remsh - trial) : remsh;
                rt_root_reg[k] <= {rt_root_reg[k-1][ROOT_W-2:0], fits};
                rt_s_reg[k]    <= rt_s_reg[k-1];
                rt_item_reg[k] <= rt_item_reg[k-1];
                rt_gx_reg[k]   <= rt_gx_reg[k-1];
                rt_gy_reg[k]   <= rt_gy_reg[k-1];
            end
        end
    end

    // Denominator S * r in two partial products, then numerators.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_c_reg <= rt_item_reg[ROOT_W];
            plo_c_reg  <= (MAG_W+ROOT_W)'(rt_s_reg[ROOT_W][MAG_W-1:0])
                          * (MAG_W+ROOT_W)'(rt_root_reg[ROOT_W]);
            phi_c_reg  <= (SQ_W-MAG_W+ROOT_W)'(rt_s_reg[ROOT_W][SQ_W-1:MAG_W])
                          * (SQ_W-MAG_W+ROOT_W)'(rt_root_reg[ROOT_W]);
            gx_c_reg   <= rt_gx_reg[ROOT_W];
            gy_c_reg   <= rt_gy_reg[ROOT_W];

            item_d_reg <= item_c_reg;
            den_d_reg  <= DEN_W'(plo_c_reg) + (DEN_W'(phi_c_reg) << MAG_W);
            numx_d_reg <= NUM_W'(gx_c_reg) << (2 * FRAC_BITS);
            numy_d_reg <= NUM_W'(gy_c_reg) << (2 * FRAC_BITS);
        end
    end

    cpdd_divider u_div_x (
        .clk  (clk),
        .adv  (adv),
        .num  (numx_d_reg),
        .den  (den_d_reg),
        .quot (quot_x)
    );

    cpdd_divider u_div_y (
        .clk  (clk),
        .adv  (adv),
        .num  (numy_d_reg),
        .den  (den_d_reg),
        .quot (quot_y)
    );

    // Side data delay matched to the dividers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dl_item_reg[0] <= item_d_reg;
            for (int j = 1; j < DIV_LAT; j++)
            begin
                dl_item_reg[j] <= dl_item_reg[j-1];
            end
        end
    end

    // Signed coupling, sums and saturation.
    assign fin   = dl_item_reg[DIV_LAT-1];
    assign ax    = fin.coincident ? '0
                 : (fin.neg_x ? -SUM_W'(quot_x) : SUM_W'(quot_x));
    assign ay    = fin.coincident ? '0
                 : (fin.neg_y ? -SUM_W'(quot_y) : SUM_W'(quot_y));
    assign sum1x = SUM_W'(fin.cmd1_x) + ax;
    assign sum1y = SUM_W'(fin.cmd1_y) + ay;
    assign sum2x = SUM_W'(fin.cmd2_x) - ax;
    assign sum2y = SUM_W'(fin.cmd2_y) - ay;

    always_ff @(posedge clk)
    begin
        if (adv && dl_valid_reg[DIV_LAT-1])
        begin
            dpos1_x_reg    <= fin.vel1_x;
            dpos1_y_reg    <= fin.vel1_y;
            dpos2_x_reg    <= fin.vel2_x;
            dpos2_y_reg    <= fin.vel2_y;
            dvel1_x_reg    <= clip_word(sum1x);
            dvel1_y_reg    <= clip_word(sum1y);
            dvel2_x_reg    <= clip_word(sum2x);
            dvel2_y_reg    <= clip_word(sum2y);
            coincident_reg <= fin.coincident;
            saturated_reg  <= clips(sum1x) || clips(sum1y) || clips(sum2x) || clips(sum2y);
        end
    end

    assign out_valid  = out_valid_reg;
    assign dpos1_x    = dpos1_x_reg;
    assign dpos1_y    = dpos1_y_reg;
    assign dvel1_x    = dvel1_x_reg;
    assign dvel1_y    = dvel1_y_reg;
    assign dpos2_x    = dpos2_x_reg;
    assign dpos2_y    = dpos2_y_reg;
    assign dvel2_x    = dvel2_x_reg;
    assign dvel2_y    = dvel2_y_reg;
    assign coincident = coincident_reg;
    assign saturated  = saturated_reg;

endmodule

@@ tb/coupled_pair_dynamics_derivative_core_tb.sv @@
`timescale 1ns / 100ps

module coupled_pair_dynamics_derivative_core_tb;
    import cpdd_pkg::*;

    // One state sample: pos1 x/y, vel1 x/y, pos2 x/y, vel2 x/y, cmd1 x/y, cmd2 x/y.
    typedef struct {
        logic signed [WORD_W-1:0] f [12];
    } sample_t;

    // One derivative: dpos1, dvel1, dpos2, dvel2 (x/y each), then the two flags.
    typedef struct {
        logic signed [WORD_W-1:0] w [8];
        logic                     coincident;
        logic                     saturated;
    } deriv_t;

    typedef struct {
        sample_t s;
        bit      typed;
        deriv_t  d;
    } row_t;

    localparam logic [127:0] CAP_VALUE = 128'd1 << 33;
    localparam int           IDLE_WAIT = 120;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [GAIN_W-1:0]        cfg_wdata;
    logic                     in_valid;
    logic                     in_stall;
    logic signed [WORD_W-1:0] pos1_x, pos1_y, vel1_x, vel1_y;
    logic signed [WORD_W-1:0] pos2_x, pos2_y, vel2_x, vel2_y;
    logic signed [WORD_W-1:0] cmd1_x, cmd1_y, cmd2_x, cmd2_y;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [WORD_W-1:0] dpos1_x, dpos1_y, dvel1_x, dvel1_y;
    logic signed [WORD_W-1:0] dpos2_x, dpos2_y, dvel2_x, dvel2_y;
    logic                     coincident;
    logic                     saturated;

    logic [GAIN_W-1:0] gain_model;
    deriv_t            deriv_q [$];
    row_t              dir_rows [$];
    int                mismatches;
    int                transfers_in;
    int                transfers_out;
    int                sat_seen;
    int                coinc_seen;
    int                hold_cycles;
    bit                noisy_stall;
    bit                noisy_gaps;

    string field_names [8] = '{"dpos1_x", "dpos1_y", "dvel1_x", "dvel1_y",
                               "dpos2_x", "dpos2_y", "dvel2_x", "dvel2_y"};

    coupled_pair_dynamics_derivative_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pos1_x     (pos1_x),
        .pos1_y     (pos1_y),
        .vel1_x     (vel1_x),
        .vel1_y     (vel1_y),
        .pos2_x     (pos2_x),
        .pos2_y     (pos2_y),
        .vel2_x     (vel2_x),
        .vel2_y     (vel2_y),
        .cmd1_x     (cmd1_x),
        .cmd1_y     (cmd1_y),
        .cmd2_x     (cmd2_x),
        .cmd2_y     (cmd2_y),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .dpos1_x    (dpos1_x),
        .dpos1_y    (dpos1_y),
        .dvel1_x    (dvel1_x),
        .dvel1_y    (dvel1_y),
        .dpos2_x    (dpos2_x),
        .dpos2_y    (dpos2_y),
        .dvel2_x    (dvel2_x),
        .dvel2_y    (dvel2_y),
        .coincident (coincident),
        .saturated  (saturated)
    );

    // Clock with a 12 ns period.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Coupling magnitude along one axis, truncated and held at the cap.
    function automatic logic [127:0] coupling_mag(logic [127:0] mag, logic [127:0] den);
        logic [127:0] num;
        logic [127:0] quo;
        num = ({97'd0, gain_model} * mag) << (2 * FRAC_BITS);
        quo = num / den;
        if (quo > CAP_VALUE)
        begin
            quo = CAP_VALUE;
        end
        return quo;
    endfunction

    // Clip a sum to the signed word range and note any clipping.
    function automatic logic signed [WORD_W-1:0] clip_word(longint v, inout logic flag);
        if (v > 64'sh7FFF_FFFF)
        begin
            flag = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sh8000_0000)
        begin
            flag = 1'b1;
            return 32'sh8000_0000;
        end
        return v[WORD_W-1:0];
    endfunction

    // Time derivative of the pair state under the current coupling gain.
    function automatic deriv_t derive_state(sample_t s);
        deriv_t       d;
        longint       dx;
        longint       dy;
        longint       ax;
        longint       ay;
        logic [127:0] mx;
        logic [127:0] my;
        logic [127:0] sq;
        logic [127:0] root;
        logic [127:0] cand;
        logic [127:0] den;
        logic         sat;
        dx  = longint'(s.f[4]) - longint'(s.f[0]);
        dy  = longint'(s.f[5]) - longint'(s.f[1]);
        ax  = 0;
        ay  = 0;
        sat = 1'b0;
        d.coincident = (dx == 0) && (dy == 0);
        if (!d.coincident)
        begin
            mx   = (dx < 0) ? 128'(-dx) : 128'(dx);
            my   = (dy < 0) ? 128'(-dy) : 128'(dy);
            sq   = mx * mx + my * my;
            root = '0;
            for (int b = 33; b >= 0; b--)
            begin
                cand = root | (128'd1 << b);
                if (cand * cand <= sq)
                begin
                    root = cand;
                end
            end
            den = sq * root;
            ax  = longint'(coupling_mag(mx, den));
            ay  = longint'(coupling_mag(my, den));
            if (dx < 0)
            begin
                ax = -ax;
            end
            if (dy < 0)
            begin
                ay = -ay;
            end
        end
        d.w[0] = s.f[2];
        d.w[1] = s.f[3];
        d.w[2] = clip_word(longint'(s.f[8]) + ax, sat);
        d.w[3] = clip_word(longint'(s.f[9]) + ay, sat);
        d.w[4] = s.f[6];
        d.w[5] = s.f[7];
        d.w[6] = clip_word(longint'(s.f[10]) - ax, sat);
        d.w[7] = clip_word(longint'(s.f[11]) - ay, sat);
        d.saturated = sat;
        return d;
    endfunction

    // Gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
        begin
            return 0;
        end
        if (roll < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 30);
    endfunction

    // Present one sample, hold it until the transfer, then record its derivative.
    task automatic send_sample(sample_t s, bit typed, deriv_t typed_d);
        deriv_t exp_d;
        in_valid <= 1'b1;
        pos1_x <= s.f[0];
        pos1_y <= s.f[1];
        vel1_x <= s.f[2];
        vel1_y <= s.f[3];
        pos2_x <= s.f[4];
        pos2_y <= s.f[5];
        vel2_x <= s.f[6];
        vel2_y <= s.f[7];
        cmd1_x <= s.f[8];
        cmd1_y <= s.f[9];
        cmd2_x <= s.f[10];
        cmd2_y <= s.f[11];
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        if (typed)
        begin
            exp_d = typed_d;
        end
        else
        begin
            exp_d = derive_state(s);
        end
        deriv_q.insert(deriv_q.size(), exp_d);
        transfers_in++;
        if (noisy_gaps)
        begin
            int gap;
            gap = pick_gap();
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Random sample, often a nearby pair so the coupling stays within range.
    function automatic sample_t random_sample();
        sample_t s;
        int      shape;
        for (int i = 0; i < 12; i++)
        begin
            s.f[i] = $urandom;
        end
        shape = $urandom_range(0, 99);
        if (shape < 10)
        begin
            s.f[4] = s.f[0];
            s.f[5] = s.f[1];
        end
        else if (shape < 55)
        begin
            s.f[4] = s.f[0] + $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            s.f[5] = s.f[1] + $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        end
        else if (shape < 65)
        begin
            s.f[5] = s.f[1];
        end
        else if (shape < 75)
        begin
            s.f[4] = s.f[0];
        end
        if ($urandom_range(0, 1) == 1)
        begin
            for (int i = 8; i < 12; i++)
            begin
                s.f[i] = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            end
        end
        return s;
    endfunction

    // Lower valid, let the pipeline drain, then change the gain.
    task automatic write_gain(logic [GAIN_W-1:0] g);
        in_valid <= 1'b0;
        @(posedge clk);
        while (deriv_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (IDLE_WAIT) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= g;
        @(posedge clk);
        cfg_we     <= 1'b0;
        gain_model  = g;
    endtask

    task automatic random_phase(int count, bit with_hold);
        deriv_t none;
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
            begin
                noisy_gaps = ($urandom_range(0, 3) != 0);
            end
            if (with_hold && n == count / 2)
            begin
                hold_cycles = 200;
            end
            send_sample(random_sample(), 1'b0, none);
        end
    endtask

    function automatic sample_t make_sample(logic signed [WORD_W-1:0] p1x,
                                            logic signed [WORD_W-1:0] p1y,
                                            logic signed [WORD_W-1:0] p2x,
                                            logic signed [WORD_W-1:0] p2y,
                                            logic signed [WORD_W-1:0] vel,
                                            logic signed [WORD_W-1:0] cmd);
        sample_t s;
        s.f[0] = p1x;
        s.f[1] = p1y;
        s.f[4] = p2x;
        s.f[5] = p2y;
        s.f[2] = vel;
        s.f[3] = ~vel;
        s.f[6] = -vel;
        s.f[7] = vel ^ 32'sh5555_5555;
        s.f[8] = cmd;
        s.f[9] = ~cmd;
        s.f[10] = cmd;
        s.f[11] = -cmd;
        return s;
    endfunction

    // A coincident row whose derivative is read straight off the inputs.
    task automatic add_coincident_row(sample_t s);
        row_t r;
        r.s     = s;
        r.typed = 1'b1;
        r.d.w[0] = s.f[2];
        r.d.w[1] = s.f[3];
        r.d.w[2] = s.f[8];
        r.d.w[3] = s.f[9];
        r.d.w[4] = s.f[6];
        r.d.w[5] = s.f[7];
        r.d.w[6] = s.f[10];
        r.d.w[7] = s.f[11];
        r.d.coincident = 1'b1;
        r.d.saturated  = 1'b0;
        dir_rows.insert(dir_rows.size(), r);
    endtask

    task automatic add_row(sample_t s);
        row_t r;
        r.s     = s;
        r.typed = 1'b0;
        dir_rows.insert(dir_rows.size(), r);
    endtask

    // Directed table: coincident extremes, tiny and huge separations, saturation.
    task automatic build_table();
        localparam logic signed [WORD_W-1:0] MAXW = 32'sh7FFF_FFFF;
        localparam logic signed [WORD_W-1:0] MINW = 32'sh8000_0000;
        localparam logic signed [WORD_W-1:0] ONE  = 32'sh0001_0000;
        add_coincident_row(make_sample(0, 0, 0, 0, 0, 0));
        add_coincident_row(make_sample(MAXW, MAXW, MAXW, MAXW, MAXW, MAXW));
        add_coincident_row(make_sample(MINW, MINW, MINW, MINW, MINW, MINW));
        add_coincident_row(make_sample(MINW, MAXW, MINW, MAXW, -1, 1));
        add_row(make_sample(0, 0, 1, 0, ONE, 0));
        add_row(make_sample(0, 0, 0, -1, 0, ONE));
        add_row(make_sample(MINW, MINW, MAXW, MAXW, MAXW, 0));
        add_row(make_sample(MAXW, MAXW, MINW, MINW, MINW, 0));
        add_row(make_sample(MINW, 0, MAXW, 0, 0, 0));
        add_row(make_sample(0, 0, ONE, 0, 0, 0));
        add_row(make_sample(0, 0, 3 * ONE, 4 * ONE, ONE, ONE));
        add_row(make_sample(ONE, ONE, -2 * ONE, -3 * ONE, -ONE, ONE));
        add_row(make_sample(0, 0, 0, ONE, 0, 0));
        add_row(make_sample(0, 0, 256, 256, 0, MAXW));
        add_row(make_sample(0, 0, -256, -256, 0, MINW));
        add_row(make_sample(0, 0, ONE, ONE, MAXW, MAXW - 5));
        add_row(make_sample(5, -7, 5 + ONE / 2, -7, 3, MINW + 3));
    endtask

    // Output stall: random bursts, quiet stretches, and one long hold-off.
    initial
    begin
        int burst;
        int cycles;
        out_stall   = 1'b0;
        hold_cycles = 0;
        burst       = 0;
        cycles      = 0;
        noisy_stall = 1'b1;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles % 400 == 0)
            begin
                noisy_stall = ($urandom_range(0, 3) != 0);
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_stall <= 1'b1;
            end
            else if (burst > 0)
            begin
                burst--;
                out_stall <= 1'b1;
            end
            else if (noisy_stall && $urandom_range(0, 99) < 25)
            begin
                burst = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                    : $urandom_range(0, 2);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Compare each transfer on the output with the oldest recorded derivative.
    initial
    begin
        deriv_t want;
        deriv_t got;
        bit     bad;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                transfers_out++;
                got.w[0] = dpos1_x;
                got.w[1] = dpos1_y;
                got.w[2] = dvel1_x;
                got.w[3] = dvel1_y;
                got.w[4] = dpos2_x;
                got.w[5] = dpos2_y;
                got.w[6] = dvel2_x;
                got.w[7] = dvel2_y;
                got.coincident = coincident;
                got.saturated  = saturated;
                sat_seen   += saturated;
                coinc_seen += coincident;
                if (deriv_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t: output transfer with nothing outstanding", $realtime);
                    end
                end
                else
                begin
                    want = deriv_q.pop_front();
                    bad  = 1'b0;
                    for (int i = 0; i < 8; i++)
                    begin
                        if (got.w[i] !== want.w[i])
                        begin
                            bad = 1'b1;
                            if (mismatches < 10)
                            begin
                                $display("%0t: %s expected %h got %h", $realtime,
                                         field_names[i], want.w[i], got.w[i]);
                            end
                        end
                    end
                    if (got.coincident !== want.coincident || got.saturated !== want.saturated)
                    begin
                        bad = 1'b1;
                        if (mismatches < 10)
                        begin
                            $display("%0t: flags expected coincident %b saturated %b, got %b %b",
                                     $realtime, want.coincident, want.saturated,
                                     got.coincident, got.saturated);
                        end
                    end
                    if (bad)
                    begin
                        mismatches++;
                    end
                end
            end
        end
    end

    // Main sequence: reset, directed table, then random phases over several gains.
    initial
    begin
        deriv_t none;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        in_valid   = 1'b0;
        {pos1_x, pos1_y, vel1_x, vel1_y} = '0;
        {pos2_x, pos2_y, vel2_x, vel2_y} = '0;
        {cmd1_x, cmd1_y, cmd2_x, cmd2_y} = '0;
        gain_model    = GAIN_RESET;
        mismatches    = 0;
        transfers_in  = 0;
        transfers_out = 0;
        sat_seen      = 0;
        coinc_seen    = 0;
        noisy_gaps    = 1'b1;
        build_table();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            send_sample(dir_rows[i].s, dir_rows[i].typed, dir_rows[i].d);
        end
        random_phase(110, 1'b1);

        write_gain('0);
        random_phase(60, 1'b0);
        write_gain({GAIN_W{1'b1}});
        random_phase(60, 1'b0);
        write_gain(GAIN_W'($urandom));
        random_phase(100, 1'b0);
        write_gain(GAIN_W'($urandom_range(1, 32'h0004_0000)));
        random_phase(100, 1'b0);
        write_gain(GAIN_RESET);
        foreach (dir_rows[i])
        begin
            if (!dir_rows[i].typed)
            begin
                send_sample(dir_rows[i].s, 1'b0, none);
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (deriv_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (IDLE_WAIT) @(posedge clk);

        $display("Sent %0d samples over six gain settings; %0d derivatives checked,",
                 transfers_in, transfers_out);
        $display("%0d saturated, %0d coincident, %0d mismatches.",
                 sat_seen, coinc_seen, mismatches);
        if (mismatches == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Hard limit on the run.
    initial
    begin
        #8_000_000;
        $display("Timed out with %0d derivatives outstanding.", deriv_q.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/cpdd_pkg.sv
rtl/core/cpdd_front.sv
rtl/core/cpdd_queue.sv
rtl/core/cpdd_divider.sv
rtl/core/cpdd_back.sv
rtl/core/coupled_pair_dynamics_derivative_core.sv
tb/coupled_pair_dynamics_derivative_core_tb.sv
